// File: src/aecho_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo delay line package
// Shared constants, register indexes, state codes and arithmetic helpers.
// ----------------------------------------------------------------------------
package aecho_pkg;

    localparam int StoreDepth = 65536;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int LenW       = AddrW + 1;
    localparam int FracW      = AddrW + 8;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 17;
    localparam int QueueDepth = 2;
    localparam logic [15:0] MixPassLimit   = 16'd327;
    localparam logic [15:0] GainOne        = 16'h8000;
    localparam logic [15:0] ReadStartReset = 16'd512;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ECHO_LENGTH  = 3'd0,
        REG_READ_START   = 3'd1,
        REG_DECAY        = 3'd2,
        REG_MIX          = 3'd3,
        REG_PITCH_MODE   = 3'd4,
        REG_STEP_RATE    = 3'd5,
        REG_NARROW       = 3'd6,
        REG_SIGNED       = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE,
        ST_RUN_MOD,
        ST_RUN_READ,
        ST_RUN_CALC,
        ST_RUN_WRITE,
        ST_OUT
    } eng_state_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic               src;
        logic               pass;
        logic signed [15:0] s;
        logic [15:0]        pass_val;
    } item_t;

    // Shift right by 15, rounding toward zero.
    function automatic logic signed [33:0] trunc_q15(input logic signed [48:0] v);
        logic signed [48:0] t;
        t = v[48] ? (v + 49'sd32767) : v;
        return t[48:15];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) return 16'sh7fff;
        if (v < -34'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] sat8(input logic signed [33:0] v);
        if (v > 34'sd127) return 16'sd127;
        if (v < -34'sd128) return -16'sd128;
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

// File: src/aecho_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo delay line front end
// Accepts samples, converts format, decides the low-mix pass, feeds a queue.
// ----------------------------------------------------------------------------
module aecho_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  s_has_source,
    input  wire  [15:0]          s_sample_in,
    input  wire                  narrow,
    input  wire                  sgn,
    input  wire  [15:0]          mix,
    input  wire                  q_pop,
    output logic                 q_valid,
    output aecho_pkg::item_t     q_item
);
    import aecho_pkg::*;

    item_t             mem_reg [QueueDepth];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg;
    item_t             cls;
    logic [15:0]       b;

    // Classify the incoming transfer
    always_comb begin
        cls.src = s_has_source;
        cls.pass = (mix <= MixPassLimit);
        if (narrow) begin
            b = {8'd0, s_sample_in[7:0] ^ (sgn ? 8'h00 : 8'h80)};
            cls.s = {{8{b[7]}}, b[7:0]};
        end else begin
            b = s_sample_in ^ (sgn ? 16'h0000 : 16'h8000);
            cls.s = b;
        end
        if (!s_has_source) cls.s = '0;
        if (s_has_source) cls.pass_val = narrow ? {8'd0, s_sample_in[7:0]} : s_sample_in;
        else if (sgn) cls.pass_val = '0;
        else cls.pass_val = narrow ? 16'h0080 : 16'h8000;
    end

    assign s_ready = (cnt_reg != 2'(QueueDepth));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) mem_reg[wr_ptr_reg] <= cls;
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (s_valid && s_ready) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(s_valid && s_ready) - 2'(q_pop);
        end
    end
endmodule
`default_nettype wire

// File: src/aecho_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo delay line back end
// Runs the ring read-modify-write sequence and produces the output sample.
// ----------------------------------------------------------------------------
module aecho_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    input  aecho_pkg::item_t     q_item,
    output logic                 q_pop,
    input  wire  [16:0]          echo_length,
    input  wire  [15:0]          read_start,
    input  wire                  rs_load,
    input  wire  [15:0]          decay,
    input  wire  [15:0]          mix,
    input  wire                  pitch_mode,
    input  wire  [15:0]          step_rate,
    input  wire                  narrow,
    input  wire                  sgn,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [15:0]          m_sample_out
);
    import aecho_pkg::*;

    logic [15:0]               ram [StoreDepth];
    logic [AddrW-1:0]          raddr, waddr;
    logic                      we;
    logic [15:0]               rdata_reg;
    logic [15:0]               wdata;

    eng_state_t                state_reg, state_next;
    logic [AddrW-1:0]          rp_reg, wp_reg;
    logic [FracW-1:0]          fp_reg;
    logic [AddrW:0]            clr_reg;
    logic                      clearing;
    item_t                     it_reg;
    logic signed [15:0]        e_reg;
    logic [FracW-1:0]          pos_reg;
    logic [FracW:0]            next_reg;
    logic [FracW-8:0]          j_reg;
    logic [AddrW-1:0]          k_reg;
    logic signed [31:0]        prod_reg;
    logic signed [15:0]        fb;
    logic [15:0]               out_reg, out_next;
    logic                      out_valid_reg;
    logic [AddrW-1:0]          rem_reg;
    logic [AddrW-1:0]          div_q_reg;
    logic [3:0]                div_cnt_reg;
    logic [AddrW:0]            rem_sh, rem_new;
    logic                      fp_wide;

    logic [LenW-1:0]           len;
    logic [15:0]               g, m, dm;
    logic [FracW:0]            pos_c;
    logic [FracW:0]            nxt_c;
    logic signed [16:0]        wet;
    logic signed [32:0]        dry_p, wet_p, echo_p;
    logic signed [48:0]        macc;
    logic signed [33:0]        mixed;
    logic signed [15:0]        mixed_sat;

    assign len  = (echo_length == '0) ? LenW'(1) :
                  (echo_length > LenW'(StoreDepth)) ? LenW'(StoreDepth) : echo_length;
    assign g    = (decay > GainOne) ? GainOne : decay;
    assign m    = (mix > GainOne) ? GainOne : mix;
    assign dm   = GainOne - m;
    assign clearing = !clr_reg[AddrW];

    // Pointer past the ring after a length change needs a remainder pass
    assign fp_wide = (LenW'(fp_reg[FracW-1:8]) >= len);

    // One restoring step of the entry-index remainder by the ring length
    assign rem_sh  = {rem_reg, div_q_reg[AddrW-1]};
    assign rem_new = (rem_sh >= len) ? rem_sh - len : rem_sh;

    // Ring memory
    always_ff @(posedge aclk) begin
        if (we) ram[waddr] <= wdata;
        rdata_reg <= ram[raddr];
    end

    // Feedback value from registered product
    always_comb begin
        logic signed [48:0] acc;
        acc = 49'(prod_reg) + (49'(it_reg.s) <<< 15);
        fb = (it_reg.src && narrow) ? sat8(trunc_q15(acc)) : sat16(trunc_q15(acc));
    end

    // Output blend and fractional pointer position
    always_comb begin
        wet = 17'(e_reg) + 17'(it_reg.s);
        if (wet > 17'sd32767) wet = 17'sd32767;
        if (wet < -17'sd32768) wet = -17'sd32768;
        dry_p  = it_reg.s * $signed({1'b0, dm});
        wet_p  = wet * $signed({1'b0, m});
        echo_p = e_reg * $signed({1'b0, m});
        if (it_reg.src)
            macc = 49'(dry_p) + 49'(wet_p);
        else
            macc = 49'(echo_p);
        mixed = trunc_q15(macc);
        mixed_sat = narrow ? sat8(mixed) : sat16(mixed);
        if (narrow) out_next = {8'd0, mixed_sat[7:0] ^ (sgn ? 8'h00 : 8'h80)};
        else out_next = mixed_sat ^ (sgn ? 16'h0000 : 16'h8000);
        if (state_reg == ST_RUN_MOD) pos_c = {1'b0, rem_new[AddrW-1:0], fp_reg[7:0]};
        else pos_c = {1'b0, fp_reg};
        nxt_c = pos_c + (FracW+1)'(step_rate);
    end

    // Next state and memory control
    always_comb begin
        state_next = state_reg;
        q_pop = 1'b0;
        we = 1'b0;
        waddr = wp_reg;
        wdata = fb;
        raddr = rp_reg;
        if (clearing) begin
            we = 1'b1;
            waddr = clr_reg[AddrW-1:0];
            wdata = '0;
        end
        case (state_reg)
            ST_IDLE: begin
                raddr = AddrW'(pos_c >> 8);
                if (q_valid && !clearing && !out_valid_reg) begin
                    q_pop = 1'b1;
                    if (q_item.pass) state_next = ST_OUT;
                    else if (pitch_mode) state_next = fp_wide ? ST_RUN_MOD : ST_RUN_READ;
                    else state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_WRITE;
            ST_WRITE: begin
                we = 1'b1;
                state_next = ST_OUT;
            end
            ST_RUN_MOD: begin
                raddr = AddrW'(pos_c >> 8);
                state_next = (div_cnt_reg == 4'd0) ? ST_RUN_READ : ST_RUN_MOD;
            end
            ST_RUN_READ: begin
                raddr = k_reg;
                state_next = (j_reg < (FracW-7)'(next_reg >> 8)) ? ST_RUN_CALC : ST_OUT;
            end
            ST_RUN_CALC: state_next = ST_RUN_WRITE;
            ST_RUN_WRITE: begin
                we = 1'b1;
                waddr = k_reg;
                state_next = ST_RUN_READ;
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // Datapath and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg        <= ReadStartReset;
            wp_reg        <= '0;
            fp_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (rs_load) rp_reg <= read_start;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        it_reg      <= q_item;
                        pos_reg     <= pos_c[FracW-1:0];
                        next_reg    <= nxt_c;
                        j_reg       <= (FracW-7)'(pos_c >> 8);
                        k_reg       <= AddrW'(pos_c >> 8);
                        rem_reg     <= '0;
                        div_q_reg   <= fp_reg[FracW-1:8];
                        div_cnt_reg <= 4'(AddrW - 1);
                        if (q_item.pass) out_reg <= q_item.pass_val;
                    end
                end
                ST_READ: ;
                ST_CALC: begin
                    e_reg    <= rdata_reg;
                    prod_reg <= $signed(rdata_reg) * $signed({1'b0, g});
                end
                ST_WRITE: begin
                    rp_reg <= ((LenW'(rp_reg) + 1'b1) >= len) ? '0 : rp_reg + 1'b1;
                    wp_reg <= ((LenW'(wp_reg) + 1'b1) >= len) ? '0 : wp_reg + 1'b1;
                end
                ST_RUN_MOD: begin
                    rem_reg     <= rem_new[AddrW-1:0];
                    div_q_reg   <= {div_q_reg[AddrW-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == 4'd0) begin
                        pos_reg  <= pos_c[FracW-1:0];
                        next_reg <= nxt_c;
                        j_reg    <= (FracW-7)'(pos_c >> 8);
                        k_reg    <= AddrW'(pos_c >> 8);
                    end
                end
                ST_RUN_READ: begin
                    // First visit holds the entry at the start position
                    if (j_reg == (FracW-7)'(pos_reg >> 8)) e_reg <= rdata_reg;
                    if (state_next == ST_OUT)
                        fp_reg <= {k_reg, next_reg[7:0]};
                end
                ST_RUN_CALC: begin
                    prod_reg <= $signed(rdata_reg) * $signed({1'b0, g});
                end
                ST_RUN_WRITE: begin
                    j_reg <= j_reg + 1'b1;
                    k_reg <= ((LenW'(k_reg) + 1'b1) >= len) ? '0 : k_reg + 1'b1;
                end
                ST_OUT: begin
                    if (!it_reg.pass) out_reg <= out_next;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_reg;
endmodule
`default_nettype wire

// File: src/audio_echo_delay_line.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Audio echo delay line
// Feedback echo over a 16-bit ring with normal and pitch-shift pointer modes.
//
//   Channel | Signals                                  | Direction
//   s_      | s_valid s_ready s_has_source s_sample_in | in
//   m_      | m_valid m_ready m_sample_out             | out
//   cfg     | cfg_we cfg_idx cfg_data                  | in
//
// Normal mode per sample: pop, ring read, multiply, write-back, output register,
// hand-off; the next sample is popped only once the output has been taken.
// Pitch-shift mode: N ring entries read, multiplied and rewritten per sample, after
// a remainder pass when a new echo length leaves the pointer past the ring's end.
// Low-mix pass skips the ring. A two-entry queue decouples input from the engine.
// After reset all 65536 ring entries are cleared; no sample starts until then.
// ----------------------------------------------------------------------------
module audio_echo_delay_line (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_has_source,
    input  wire  [15:0]                       s_sample_in,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [15:0]                       m_sample_out,
    input  wire                               cfg_we,
    input  wire  [aecho_pkg::CfgIdxW-1:0]     cfg_idx,
    input  wire  [aecho_pkg::CfgDataW-1:0]    cfg_data
);
    import aecho_pkg::*;

    logic [16:0] echo_length_reg;
    logic [15:0] decay_reg, mix_reg, step_rate_reg;
    logic        pitch_mode_reg, narrow_reg, signed_reg;
    logic        rs_load, q_valid, q_pop;
    item_t       q_item;

    // Read start goes straight to the read pointer
    assign rs_load = cfg_we && (cfg_idx_t'(cfg_idx) == REG_READ_START);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_length_reg <= 17'd12000;
            decay_reg       <= 16'd22938;
            mix_reg         <= 16'd16384;
            pitch_mode_reg  <= 1'b0;
            step_rate_reg   <= 16'd256;
            narrow_reg      <= 1'b0;
            signed_reg      <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                REG_ECHO_LENGTH: echo_length_reg <= cfg_data;
                REG_READ_START:  ;
                REG_DECAY:       decay_reg       <= cfg_data[15:0];
                REG_MIX:         mix_reg         <= cfg_data[15:0];
                REG_PITCH_MODE:  pitch_mode_reg  <= cfg_data[0];
                REG_STEP_RATE:   step_rate_reg   <= cfg_data[15:0];
                REG_NARROW:      narrow_reg      <= cfg_data[0];
                REG_SIGNED:      signed_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aecho_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_has_source, .s_sample_in,
        .narrow(narrow_reg), .sgn(signed_reg), .mix(mix_reg),
        .q_pop, .q_valid, .q_item
    );

    aecho_back u_back (
        .aclk, .aresetn, .q_valid, .q_item, .q_pop,
        .echo_length(echo_length_reg), .read_start(cfg_data[15:0]), .rs_load,
        .decay(decay_reg), .mix(mix_reg), .pitch_mode(pitch_mode_reg),
        .step_rate(step_rate_reg), .narrow(narrow_reg), .sgn(signed_reg),
        .m_valid, .m_ready, .m_sample_out
    );
endmodule
`default_nettype wire

// File: src/aecho_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo delay line port checker
// Handshake and output format checks on the top-level ports.
// ----------------------------------------------------------------------------
module aecho_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [15:0] m_sample_out,
    input wire        s_ready
);
    // Hold output until transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)) else $error("out hold");
    // No output right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid) else $error("rst valid");
    // Ready comes up after reset
    a_rdy: assert property (@(posedge aclk) !aresetn |=> s_ready) else $error("rst ready");
endmodule

bind audio_echo_delay_line aecho_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_sample_out, .s_ready
);
`default_nettype wire

// File: tb/sv/audio_echo_delay_line_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio echo delay line testbench
// Sends directed and random samples through several register settings and
// checks every output sample against a table value or a local model of the
// echo ring. Both channels idle at random, and the output side holds off once
// for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module audio_echo_delay_line_tb;
    import aecho_pkg::*;

    localparam int IdleLimit = 400000;

    typedef struct {
        bit          src;
        logic [15:0] raw;
        bit          known;
        logic [15:0] out;
    } direct_row_t;

    typedef struct {
        int unsigned len;
        int unsigned rstart;
        int unsigned dec;
        int unsigned mx;
        int unsigned fs;
        int unsigned rate;
        int unsigned nar;
        int unsigned sgn;
        int          items;
    } setting_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_has_source;
    logic [15:0] s_sample_in;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_sample_out;
    logic        cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    // Model state
    shortint     ring [StoreDepth];
    int unsigned rd_ptr, wr_ptr, frac_ptr;
    int unsigned r_len, r_rstart, r_decay, r_mix, r_fs, r_rate, r_narrow, r_signed;

    logic [15:0] pending_out [$];
    int          err_count;
    int          sent_count;
    int          burst_left;
    bit          hold_done;

    audio_echo_delay_line u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_has_source (s_has_source),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint shr15(longint v);
        if (v < 0) return -((-v) >>> 15);
        return v >>> 15;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic shortint echo_feedback(longint e, longint s, longint g, bit src);
        longint w;
        w = shr15(e * g + s * 32768);
        if (src && r_narrow != 0) return shortint'(clip(w, -128, 127));
        return shortint'(clip(w, -32768, 32767));
    endfunction

    // Advance the echo model by one sample and return the expected output
    function automatic logic [15:0] echo_output(bit src, logic [15:0] raw);
        int unsigned len, m, g, b, wrap, pos, nxt, rp, wp;
        longint      s, e, mixed;
        len = r_len;
        m   = r_mix > 32768 ? 32768 : r_mix;
        g   = r_decay > 32768 ? 32768 : r_decay;
        if (len == 0) len = 1;
        if (len > StoreDepth) len = StoreDepth;
        if (r_narrow != 0) begin
            b = raw[7:0];
            if (r_signed == 0) b = b ^ 32'h80;
            s = b >= 128 ? longint'(b) - 256 : longint'(b);
        end else begin
            b = raw;
            if (r_signed == 0) b = b ^ 32'h8000;
            s = b >= 32768 ? longint'(b) - 65536 : longint'(b);
        end
        if (!src) s = 0;

        // Low mix: pass dry sample or silence, no state change
        if (m <= MixPassLimit) begin
            if (src) return r_narrow != 0 ? {8'h00, raw[7:0]} : raw;
            if (r_signed != 0) return 16'h0000;
            return r_narrow != 0 ? 16'h0080 : 16'h8000;
        end

        if (r_fs != 0) begin
            wrap = len << 8;
            pos  = frac_ptr % wrap;
            nxt  = pos + r_rate;
            e    = ring[(pos >> 8) % len];
            for (int unsigned j = pos >> 8; j < (nxt >> 8); j++)
                ring[j % len] = echo_feedback(ring[j % len], s, g, src);
            frac_ptr = nxt % wrap;
        end else begin
            rp = rd_ptr % StoreDepth;
            wp = wr_ptr % StoreDepth;
            e  = ring[rp];
            ring[wp] = echo_feedback(e, s, g, src);
            rp++;
            wp++;
            rd_ptr = rp >= len ? 0 : rp;
            wr_ptr = wp >= len ? 0 : wp;
        end

        if (src)
            mixed = shr15(s * (32768 - m) + clip(e + s, -32768, 32767) * m);
        else
            mixed = shr15(e * m);

        if (r_narrow != 0) begin
            mixed = clip(mixed, -128, 127);
            return {8'h00, mixed[7:0] ^ (r_signed != 0 ? 8'h00 : 8'h80)};
        end
        mixed = clip(mixed, -32768, 32767);
        return mixed[15:0] ^ (r_signed != 0 ? 16'h0000 : 16'h8000);
    endfunction

    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        @(negedge aclk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CfgDataW-1:0];
        case (idx)
            REG_ECHO_LENGTH: r_len    = val & 32'h1ffff;
            REG_READ_START: begin
                r_rstart = val & 32'hffff;
                rd_ptr   = r_rstart;
            end
            REG_DECAY:       r_decay  = val & 32'hffff;
            REG_MIX:         r_mix    = val & 32'hffff;
            REG_PITCH_MODE:  r_fs     = val & 1;
            REG_STEP_RATE:   r_rate   = val & 32'hffff;
            REG_NARROW:      r_narrow = val & 1;
            REG_SIGNED:      r_signed = val & 1;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offer one sample, hold it until transfer, then queue its expected output
    task automatic send_sample(bit src, logic [15:0] raw, bit known, logic [15:0] out);
        logic [15:0] predicted;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_has_source <= src;
        s_sample_in  <= raw;
        do @(posedge aclk); while (!s_ready);
        predicted = echo_output(src, raw);
        pending_out.push_back(known ? out : predicted);
        sent_count++;
        burst_left--;
    endtask

    // Drop valid and wait until every expected output has come out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_sample();
        logic [15:0] raw;
        case ($urandom_range(0, 9))
            0:       raw = 16'h7fff;
            1:       raw = 16'h8000;
            2:       raw = {8'h00, 8'($urandom_range(126, 129))};
            default: raw = 16'($urandom);
        endcase
        send_sample($urandom_range(0, 4) != 0, raw, 1'b0, 16'h0000);
    endtask

    // Output side: stall on its own pattern, with one long hold-off
    initial begin
        int mode, hold;
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            if (!hold_done && sent_count >= 400) begin
                hold_done = 1'b1;
                hold      = 600;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                $error("sample_out: unexpected output %h", m_sample_out);
                err_count++;
            end else begin
                want = pending_out.pop_front();
                if (m_sample_out !== want) begin
                    $error("sample_out: expected %h, actual %h", want, m_sample_out);
                    err_count++;
                end
            end
        end
    end

    // Stop a run in which nothing moves
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
            if (idle >= IdleLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        direct_row_t rows [] = '{
            '{1, 16'h7fff, 1, 16'h7fff},
            '{1, 16'h8000, 1, 16'h8000},
            '{0, 16'h1234, 1, 16'h0000},
            '{1, 16'h0000, 1, 16'h0000},
            '{1, 16'h4000, 0, 16'h0000},
            '{1, 16'hc000, 0, 16'h0000},
            '{0, 16'hffff, 0, 16'h0000},
            '{1, 16'h0001, 0, 16'h0000},
            '{1, 16'hffff, 0, 16'h0000},
            '{0, 16'h0000, 0, 16'h0000},
            '{1, 16'h7fff, 0, 16'h0000},
            '{1, 16'h7fff, 0, 16'h0000}
        };
        setting_t plan [] = '{
            '{1,      0,     32768, 32768, 0, 256,   0, 1, 100},
            '{65536,  65535, 65535, 65535, 0, 256,   0, 0, 150},
            '{300,    40,    20000, 300,   0, 256,   1, 0, 80},
            '{0,      0,     0,     327,   0, 256,   1, 1, 40},
            '{0,      0,     0,     328,   0, 256,   0, 1, 40},
            '{64,     3,     30000, 20000, 1, 384,   0, 1, 250},
            '{131071, 7,     25000, 328,   1, 0,     1, 1, 60},
            '{5,      2,     32768, 32768, 1, 65535, 0, 0, 20},
            '{200,    9,     31000, 24000, 1, 1,     1, 0, 200},
            '{1,      0,     28000, 30000, 1, 700,   0, 1, 80},
            '{1000,   999,   26000, 10000, 0, 256,   1, 1, 250}
        };
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_has_source = 1'b0;
        s_sample_in  = 16'h0000;
        cfg_we       = 1'b0;
        cfg_idx      = REG_ECHO_LENGTH;
        cfg_data     = '0;
        err_count    = 0;
        sent_count   = 0;
        burst_left   = 0;
        hold_done    = 1'b0;
        foreach (ring[i]) ring[i] = 0;
        r_len = 12000; r_rstart = 512; r_decay = 22938; r_mix = 16384;
        r_fs = 0; r_rate = 256; r_narrow = 0; r_signed = 1;
        rd_ptr = 512; wr_ptr = 0; frac_ptr = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: directed rows, then random samples
        foreach (rows[i]) send_sample(rows[i].src, rows[i].raw, rows[i].known, rows[i].out);
        repeat (100) random_sample();
        drain();

        // Fixed settings, extremes among them, then a few random ones
        for (int p = 0; p < plan.size() + 3; p++) begin
            setting_t st;
            if (p < plan.size()) st = plan[p];
            else st = '{$urandom_range(1, 4096), $urandom_range(0, 65535),
                        $urandom_range(0, 32768), $urandom_range(328, 32768),
                        $urandom_range(0, 1), $urandom_range(1, 1023),
                        $urandom_range(0, 1), $urandom_range(0, 1), 100};
            write_reg(REG_ECHO_LENGTH, st.len);
            write_reg(REG_READ_START, st.rstart);
            write_reg(REG_DECAY, st.dec);
            write_reg(REG_MIX, st.mx);
            write_reg(REG_PITCH_MODE, st.fs);
            write_reg(REG_STEP_RATE, st.rate);
            write_reg(REG_NARROW, st.nar);
            write_reg(REG_SIGNED, st.sgn);
            repeat (st.items) random_sample();
            drain();
        end

        if (err_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
